// ----- src/atrtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrtd_pkg
// Shared types, codes and pattern tables for the reply terminator detector.
// ----------------------------------------------------------------------------
package atrtd_pkg;

	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	localparam logic [1:0] ST_SEARCH   = 2'd0;
	localparam logic [1:0] ST_FOUND    = 2'd1;
	localparam logic [1:0] ST_TIMEOUT  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_OK      = 3'd1;
	localparam logic [2:0] KIND_ERROR   = 3'd2;
	localparam logic [2:0] KIND_UNKNOWN = 3'd3;
	localparam logic [2:0] KIND_READY   = 3'd4;

	localparam logic [1:0] REG_MATCH_MODE    = 2'd0;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
	localparam logic [1:0] REG_BUFFER_LIMIT  = 2'd2;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [3:0] FLAGS_ALL = 4'hF;

	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
	localparam logic [15:0] LIMIT_RESET   = 16'd256;

	// Search state carried from item to item
	typedef struct packed {
		logic        cr_at;
		logic        cr_rdy;
		logic [7:0]  last_raw;
		logic [3:0]  line_pos;
		logic [3:0]  flags;
		logic [15:0] byte_count;
		logic [31:0] elapsed;
		logic [1:0]  fstatus;
		logic [2:0]  fkind;
	} state_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] timeout;
		logic [15:0] limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  line_kind;
		logic [15:0] end_position;
	} result_t;

	// Outcome of scanning one byte against the four patterns
	typedef struct packed {
		logic [3:0] flags_app;
		logic [3:0] pos_app;
		logic [2:0] kind;
		logic [3:0] flags_restart;
	} match_t;

	function automatic logic [7:0] pat_ok(input logic [3:0] pos);
		case (pos)
			4'd0: pat_ok = CH_CR;
			4'd1: pat_ok = CH_LF;
			4'd2: pat_ok = 8'h4F;
			4'd3: pat_ok = 8'h4B;
			4'd4: pat_ok = CH_CR;
			4'd5: pat_ok = CH_LF;
			default: pat_ok = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_error(input logic [3:0] pos);
		case (pos)
			4'd0: pat_error = CH_CR;
			4'd1: pat_error = CH_LF;
			4'd2: pat_error = 8'h45;
			4'd3: pat_error = 8'h52;
			4'd4: pat_error = 8'h52;
			4'd5: pat_error = 8'h4F;
			4'd6: pat_error = 8'h52;
			4'd7: pat_error = CH_CR;
			4'd8: pat_error = CH_LF;
			default: pat_error = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_unknown(input logic [3:0] pos);
		case (pos)
			4'd0:  pat_unknown = 8'h55;
			4'd1:  pat_unknown = 8'h6E;
			4'd2:  pat_unknown = 8'h6B;
			4'd3:  pat_unknown = 8'h6E;
			4'd4:  pat_unknown = 8'h6F;
			4'd5:  pat_unknown = 8'h77;
			4'd6:  pat_unknown = 8'h6E;
			4'd7:  pat_unknown = 8'h20;
			4'd8:  pat_unknown = 8'h63;
			4'd9:  pat_unknown = 8'h6D;
			4'd10: pat_unknown = 8'h64;
			4'd11: pat_unknown = 8'h3A;
			default: pat_unknown = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_ready(input logic [3:0] pos);
		case (pos)
			4'd0: pat_ready = CH_CR;
			4'd1: pat_ready = CH_LF;
			4'd2: pat_ready = 8'h72;
			4'd3: pat_ready = 8'h65;
			4'd4: pat_ready = 8'h61;
			4'd5: pat_ready = 8'h64;
			4'd6: pat_ready = 8'h79;
			4'd7: pat_ready = CH_CR;
			4'd8: pat_ready = CH_LF;
			default: pat_ready = 8'h00;
		endcase
	endfunction

	// Drop each pattern flag whose character at pos differs from b
	function automatic logic [3:0] clear_if_differs(input logic [3:0] flags,
			input logic [3:0] pos, input logic [7:0] b);
		logic [3:0] f;
		f = flags;
		if (pos < 4'd6  && b != pat_ok(pos))      f[0] = 1'b0;
		if (pos < 4'd9  && b != pat_error(pos))   f[1] = 1'b0;
		if (pos < 4'd12 && b != pat_unknown(pos)) f[2] = 1'b0;
		if (pos < 4'd9  && b != pat_ready(pos))   f[3] = 1'b0;
		return f;
	endfunction

endpackage

// ----- src/at_response_terminator_detect_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_terminator_detect_core
// Scans received modem bytes and ticks for the line that ends a reply.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then its result is
//   loaded into the result register; next state and result are combinational.
// Throughput: one item per cycle while the result side is not stalled, one result per item.
// Reset: arst_n clears the search state, the handshake flags and the
//   configuration registers (mode 0, timeout 1000 ticks, limit 256 bytes).
// ----------------------------------------------------------------------------
module at_response_terminator_detect_core import atrtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] command
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [1:0] status, [4:2] line_kind, [20:5] end_position
);

	cfg_t       cfg_q;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res;

	logic       valid_s1;
	logic [1:0] command_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;

	logic       out_valid_q;
	result_t    out_q;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= 1'b0;
			cfg_q.timeout <= TIMEOUT_RESET;
			cfg_q.limit   <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATCH_MODE:    cfg_q.mode    <= cfg_wdata[0];
				REG_TIMEOUT_TICKS: cfg_q.timeout <= cfg_wdata;
				REG_BUFFER_LIMIT:  cfg_q.limit   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// The staged item moves on whenever the result register is free or drains
	// this cycle; the input side is open whenever the stage empties.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register: hold the item until it is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			command_s1 <= s_tuser;
			rx_byte_s1 <= s_tdata;
		end
	end

	atrtd_step u_step (
		.cur     (state_q),
		.cfg     (cfg_q),
		.command (command_s1),
		.rx_byte (rx_byte_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	// Search state: advance once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cr_at      <= 1'b0;
			state_q.cr_rdy     <= 1'b0;
			state_q.last_raw   <= 8'h00;
			state_q.line_pos   <= 4'd0;
			state_q.flags      <= FLAGS_ALL;
			state_q.byte_count <= 16'd0;
			state_q.elapsed    <= 32'd0;
			state_q.fstatus    <= ST_SEARCH;
			state_q.fkind      <= KIND_NONE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.end_position, out_q.line_kind, out_q.status};

endmodule

// ----- src/atrtd_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrtd_match
// Pattern compare for one received byte: flag update, line kind, restart flags.
// ----------------------------------------------------------------------------
module atrtd_match import atrtd_pkg::*; (
	input  logic [3:0] flags,
	input  logic [3:0] line_pos,
	input  logic [7:0] rx_byte,
	input  logic [7:0] last_raw,
	input  logic       mode,
	output match_t     m
);

	always_comb begin
		m.flags_app = clear_if_differs(flags, line_pos, rx_byte);
		m.pos_app   = (line_pos < 4'd15) ? line_pos + 4'd1 : line_pos;
		m.kind      = KIND_NONE;
		if (last_raw == CH_CR) begin
			if (!mode) begin
				if (m.flags_app[0] && m.pos_app >= 4'd6)       m.kind = KIND_OK;
				else if (m.flags_app[1] && m.pos_app >= 4'd9)  m.kind = KIND_ERROR;
				else if (m.flags_app[2] && m.pos_app >= 4'd12) m.kind = KIND_UNKNOWN;
			end else begin
				if (m.flags_app[3] && m.pos_app >= 4'd9) m.kind = KIND_READY;
			end
		end
		// new line starts at the byte before this line feed
		m.flags_restart = clear_if_differs(clear_if_differs(FLAGS_ALL, 4'd0, last_raw),
			4'd1, rx_byte);
	end

endmodule

// ----- src/atrtd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrtd_step
// Next search state and result for one item.
// ----------------------------------------------------------------------------
module atrtd_step import atrtd_pkg::*; (
	input  state_t     cur,
	input  cfg_t       cfg,
	input  logic [1:0] command,
	input  logic [7:0] rx_byte,
	output state_t     nxt,
	output result_t    res
);

	match_t     m;
	logic       lf;
	logic       crlf;
	logic [31:0] tick_inc;

	atrtd_match u_match (
		.flags    (cur.flags),
		.line_pos (cur.line_pos),
		.rx_byte  (rx_byte),
		.last_raw (cur.last_raw),
		.mode     (cfg.mode),
		.m        (m)
	);

	assign lf       = (rx_byte == CH_LF);
	assign crlf     = (cfg.mode ? cur.cr_rdy : cur.cr_at) && lf;
	assign tick_inc = (cur.elapsed != 32'hFFFF_FFFF) ? cur.elapsed + 32'd1 : cur.elapsed;

	always_comb begin
		nxt = cur;
		if (command == CMD_START) begin
			nxt.last_raw   = 8'h00;
			nxt.line_pos   = 4'd0;
			nxt.flags      = FLAGS_ALL;
			nxt.byte_count = 16'd0;
			nxt.elapsed    = 32'd0;
			nxt.fstatus    = ST_SEARCH;
			nxt.fkind      = KIND_NONE;
		end else if (cur.fstatus == ST_SEARCH) begin
			if (command == CMD_BYTE) begin
				if (cur.elapsed >= cfg.timeout) begin
					nxt.fstatus = ST_TIMEOUT;
				end else begin
					if (!cfg.mode) begin
						if (rx_byte != 8'h00 && !crlf) nxt.cr_at = (rx_byte == CH_CR);
					end else begin
						if (!crlf) nxt.cr_rdy = (rx_byte == CH_CR);
					end
					nxt.flags    = m.flags_app;
					nxt.line_pos = m.pos_app;
					if (crlf && m.kind == KIND_NONE) begin
						nxt.flags    = m.flags_restart;
						nxt.line_pos = 4'd2;
					end
					nxt.last_raw = rx_byte;
					if (cur.byte_count != 16'hFFFF) nxt.byte_count = cur.byte_count + 16'd1;
					if (crlf && m.kind != KIND_NONE) begin
						nxt.fstatus = ST_FOUND;
						nxt.fkind   = m.kind;
					end else if (nxt.byte_count >= cfg.limit) begin
						nxt.fstatus = ST_OVERFLOW;
					end
				end
			end else if (command == CMD_TICK) begin
				nxt.elapsed = tick_inc;
				if (tick_inc >= cfg.timeout) nxt.fstatus = ST_TIMEOUT;
			end
		end
	end

	always_comb begin
		res.status       = nxt.fstatus;
		res.line_kind    = (nxt.fstatus == ST_FOUND) ? nxt.fkind : KIND_NONE;
		res.end_position = (nxt.fstatus == ST_FOUND) ? nxt.byte_count - 16'd1 : 16'd0;
	end

endmodule
